>>> rtl/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

  localparam int DEF_ELEM_WIDTH = 32;
  localparam int DEF_FRAC_BITS  = 16;
  localparam int N              = 3;

  typedef logic [1:0] idx_t;

  // status that rides along with each matrix through the elimination steps
  typedef struct packed {
    logic              sing;
    logic              sat;
    logic [N-1:0]      used;
    idx_t [N-1:0]      prow;
    idx_t [N-1:0]      pcol;
  } ctl_t;

endpackage

>>> rtl/m3i_step.sv
`timescale 1ns / 1ps

module m3i_step
  import m3i_pkg::*;
#(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int STEP       = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic [N-1:0][N-1:0][ELEM_WIDTH-1:0]  mat_i,
  input  ctl_t                                 ctl_i,
  output logic                                 vld_o,
  output logic [N-1:0][N-1:0][ELEM_WIDTH-1:0]  mat_o,
  output ctl_t                                 ctl_o
);

  localparam int W    = ELEM_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int NDIV = 2 * F + 1;
  localparam int QW   = 2 * F + 1;
  localparam int CW   = (QW + 1 > W + 1) ? QW + 1 : W + 1;

  localparam logic [W-1:0]   MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   MINN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]   ONE  = (F < W - 1) ? (W'(1) << F) : MAXP;
  localparam logic [2*W:0]   HALF = (2*W+1)'(1) << (F - 1);

  typedef logic [N-1:0][N-1:0][W-1:0] mat_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // round half away from zero on the magnitude, clamp; {sat, value}
  function automatic logic [W:0] fx_rnd(input logic [2*W-1:0] p, input logic ng);
    logic [2*W:0] s;
    logic [2*W:0] lim;
    logic [2*W:0] m;
    logic         ov;
    s   = ({1'b0, p} + HALF) >> F;
    lim = ng ? ((2*W+1)'(MAXP) + (2*W+1)'(1)) : (2*W+1)'(MAXP);
    ov  = s > lim;
    m   = ov ? lim : s;
    return {ov, ng ? (~m[W-1:0] + W'(1)) : m[W-1:0]};
  endfunction

  function automatic logic [W:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] d;
    logic       ov;
    d  = {a[W-1], a} - {b[W-1], b};
    ov = d[W] ^ d[W-1];
    return {ov, ov ? (d[W] ? MINN : MAXP) : d[W-1:0]};
  endfunction

  // ---------------- pivot search ----------------
  logic [W-1:0] mg   [N][N];
  logic         cand [N][N];
  logic [W-1:0] rbm  [N];
  idx_t         rbc  [N];
  logic         rbo  [N];
  logic [W-1:0] bm;
  idx_t         sbr, sbc;
  logic         sfnd;

  always_comb begin
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        mg[r][c]   = mag(mat_i[r][c]);
        cand[r][c] = !ctl_i.used[r] && !ctl_i.used[c] && (mg[r][c] != '0);
      end
    end
    for (int r = 0; r < N; r++) begin
      rbm[r] = '0;
      rbc[r] = '0;
      rbo[r] = 1'b0;
      for (int c = 0; c < N; c++) begin
        if (cand[r][c] && (!rbo[r] || mg[r][c] > rbm[r])) begin
          rbm[r] = mg[r][c];
          rbc[r] = idx_t'(c);
          rbo[r] = 1'b1;
        end
      end
    end
    bm   = '0;
    sbr  = '0;
    sbc  = '0;
    sfnd = 1'b0;
    for (int r = 0; r < N; r++) begin
      if (rbo[r] && (!sfnd || rbm[r] > bm)) begin
        bm   = rbm[r];
        sbr  = idx_t'(r);
        sbc  = rbc[r];
        sfnd = 1'b1;
      end
    end
  end

  logic a_v;
  mat_t a_mat;
  ctl_t a_ctl;
  idx_t a_br, a_bc;
  logic a_fnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mat <= mat_i;
      a_ctl <= ctl_i;
      a_br  <= sbr;
      a_bc  <= sbc;
      a_fnd <= sfnd;
    end
  end

  // ---------------- row exchange, then reciprocal divider ----------------
  mat_t         b_mat;
  ctl_t         b_ctl;
  logic [W-1:0] b_piv;

  always_comb begin
    b_mat = a_mat;
    if (a_br != a_bc) begin
      b_mat[a_br] = a_mat[a_bc];
      b_mat[a_bc] = a_mat[a_br];
    end
    b_piv = b_mat[a_bc][a_bc];
    b_ctl = a_ctl;
    b_ctl.sing = a_ctl.sing || !a_fnd;
    if (!a_ctl.sing && a_fnd) begin
      b_ctl.used[a_bc] = 1'b1;
      b_ctl.prow[STEP] = a_br;
      b_ctl.pcol[STEP] = a_bc;
    end
  end

  logic          dv_v   [NDIV+1];
  mat_t          dv_mat [NDIV+1];
  ctl_t          dv_ctl [NDIV+1];
  idx_t          dv_bc  [NDIV+1];
  logic [W-1:0]  dv_d   [NDIV+1];
  logic          dv_neg [NDIV+1];
  logic [W-1:0]  dv_rem [NDIV+1];
  logic [QW-1:0] dv_q   [NDIV+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_mat[0] <= b_mat;
      dv_ctl[0] <= b_ctl;
      dv_bc[0]  <= a_bc;
      dv_d[0]   <= mag(b_piv);
      dv_neg[0] <= b_piv[W-1];
      dv_rem[0] <= '0;
      dv_q[0]   <= '0;
    end
  end

  // restoring division of 2^(2F) by |pivot|, one quotient bit per stage
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic [W:0] rs;
    logic [W:0] df;
    logic       ge;

    assign rs = {dv_rem[i], ((i == 0) ? 1'b1 : 1'b0)};
    assign df = rs - {1'b0, dv_d[i]};
    assign ge = rs >= {1'b0, dv_d[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_mat[i+1] <= dv_mat[i];
        dv_ctl[i+1] <= dv_ctl[i];
        dv_bc[i+1]  <= dv_bc[i];
        dv_d[i+1]   <= dv_d[i];
        dv_neg[i+1] <= dv_neg[i];
        dv_rem[i+1] <= ge ? df[W-1:0] : rs[W-1:0];
        dv_q[i+1]   <= {dv_q[i][QW-2:0], ge};
      end
    end
  end

  // ---------------- round and clamp the reciprocal ----------------
  logic [CW-1:0] qx, qlim, qm;
  logic          q_ov;
  logic [W-1:0]  inv_c;
  mat_t          rc_mat;
  ctl_t          rc_ctl;

  always_comb begin
    qx   = CW'(dv_q[NDIV]) +
           CW'({dv_rem[NDIV], 1'b0} >= {1'b0, dv_d[NDIV]});
    qlim = dv_neg[NDIV] ? (CW'(MAXP) + CW'(1)) : CW'(MAXP);
    q_ov = qx > qlim;
    qm   = q_ov ? qlim : qx;
    inv_c = dv_neg[NDIV] ? (~qm[W-1:0] + W'(1)) : qm[W-1:0];
    rc_mat = dv_mat[NDIV];
    rc_mat[dv_bc[NDIV]][dv_bc[NDIV]] = ONE;
    rc_ctl = dv_ctl[NDIV];
    rc_ctl.sat = dv_ctl[NDIV].sat | (q_ov & !dv_ctl[NDIV].sing);
  end

  logic         r_v;
  mat_t         r_mat;
  ctl_t         r_ctl;
  idx_t         r_bc;
  logic [W-1:0] r_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= dv_v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_mat <= rc_mat;
      r_ctl <= rc_ctl;
      r_bc  <= dv_bc[NDIV];
      r_inv <= inv_c;
    end
  end

  // ---------------- scale the pivot row ----------------
  logic           m1_v;
  mat_t           m1_mat;
  ctl_t           m1_ctl;
  idx_t           m1_bc;
  logic [2*W-1:0] m1_p   [N];
  logic           m1_neg [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (en) begin
      m1_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mat <= r_mat;
      m1_ctl <= r_ctl;
      m1_bc  <= r_bc;
      for (int k = 0; k < N; k++) begin
        m1_p[k]   <= (2*W)'(mag(r_mat[r_bc][k])) * (2*W)'(mag(r_inv));
        m1_neg[k] <= r_mat[r_bc][k][W-1] ^ r_inv[W-1];
      end
    end
  end

  mat_t         m2_c_mat;
  ctl_t         m2_c_ctl;
  logic [W:0]   m2_rr [N];

  always_comb begin
    m2_c_mat = m1_mat;
    m2_c_ctl = m1_ctl;
    for (int k = 0; k < N; k++) begin
      m2_rr[k] = fx_rnd(m1_p[k], m1_neg[k]);
      m2_c_mat[m1_bc][k] = m2_rr[k][W-1:0];
      m2_c_ctl.sat = m2_c_ctl.sat | (m2_rr[k][W] & !m1_ctl.sing);
    end
  end

  logic m2_v;
  mat_t m2_mat;
  ctl_t m2_ctl;
  idx_t m2_bc;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (en) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_mat <= m2_c_mat;
      m2_ctl <= m2_c_ctl;
      m2_bc  <= m1_bc;
    end
  end

  // ---------------- clear the pivot column from the other rows ----------------
  logic           e1_v;
  mat_t           e1_mat;
  ctl_t           e1_ctl;
  idx_t           e1_bc;
  logic [2*W-1:0] e1_p   [N][N];
  logic           e1_neg [N][N];

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
    end else if (en) begin
      e1_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_mat <= m2_mat;
      e1_ctl <= m2_ctl;
      e1_bc  <= m2_bc;
      for (int r = 0; r < N; r++) begin
        for (int k = 0; k < N; k++) begin
          e1_p[r][k]   <= (2*W)'(mag(m2_mat[m2_bc][k])) * (2*W)'(mag(m2_mat[r][m2_bc]));
          e1_neg[r][k] <= m2_mat[m2_bc][k][W-1] ^ m2_mat[r][m2_bc][W-1];
        end
      end
    end
  end

  logic         e2_v;
  mat_t         e2_mat;
  ctl_t         e2_ctl;
  idx_t         e2_bc;
  logic [W-1:0] e2_w [N][N];
  logic         e2_s [N];
  logic [W:0]   e2_rr [N][N];
  logic         e2_sc [N];

  always_comb begin
    for (int r = 0; r < N; r++) begin
      e2_sc[r] = 1'b0;
      for (int k = 0; k < N; k++) begin
        e2_rr[r][k] = fx_rnd(e1_p[r][k], e1_neg[r][k]);
        e2_sc[r]    = e2_sc[r] | e2_rr[r][k][W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_v <= 1'b0;
    end else if (en) begin
      e2_v <= e1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_mat <= e1_mat;
      e2_ctl <= e1_ctl;
      e2_bc  <= e1_bc;
      for (int r = 0; r < N; r++) begin
        e2_s[r] <= e2_sc[r];
        for (int k = 0; k < N; k++) begin
          e2_w[r][k] <= e2_rr[r][k][W-1:0];
        end
      end
    end
  end

  mat_t       e3_mat;
  ctl_t       e3_ctl;
  logic [W:0] e3_d [N][N];
  logic [W-1:0] e3_a [N][N];

  always_comb begin
    e3_mat = e2_mat;
    e3_ctl = e2_ctl;
    for (int r = 0; r < N; r++) begin
      for (int k = 0; k < N; k++) begin
        // the pivot column entry is zeroed before the subtraction
        e3_a[r][k] = (idx_t'(k) == e2_bc) ? '0 : e2_mat[r][k];
        e3_d[r][k] = sat_sub(e3_a[r][k], e2_w[r][k]);
      end
      if (idx_t'(r) != e2_bc) begin
        for (int k = 0; k < N; k++) begin
          e3_mat[r][k] = e3_d[r][k][W-1:0];
          e3_ctl.sat   = e3_ctl.sat | (e3_d[r][k][W] & !e2_ctl.sing);
        end
        e3_ctl.sat = e3_ctl.sat | (e2_s[r] & !e2_ctl.sing);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_o <= e3_mat;
      ctl_o <= e3_ctl;
    end
  end

endmodule

>>> rtl/matrix3x3_inverse.sv
`timescale 1ns / 1ps

// 3x3 matrix inverter, signed fixed point (Q16.16 by default), Gauss-Jordan
// elimination with full pivoting.
// Input channel: mat_valid / mat_stall with m00..m22; a beat is taken on a
// rising edge with mat_valid high and mat_stall low.
// Output channel: inv_valid / inv_stall with r00..r22, singular, saturated.
// Throughput: one matrix per cycle while mat_stall is low. Each of the three
// elimination steps is a pipeline of 2*FRAC_BITS+9 stages, set by the
// bit-per-stage reciprocal divider; the output register follows the last step.
// A singular matrix gives singular=1 with zero elements; any clamp on the way
// sets saturated unless the matrix is singular.
// Reset (rst, synchronous) empties the pipeline and the output buffer.
// When the receiver stalls, the result holds and one more beat is caught in a
// skid register; the pipeline then freezes and mat_stall rises until the
// skid drains. Nothing is dropped or repeated.

module matrix3x3_inverse
  import m3i_pkg::*;
#(
  parameter int ELEM_WIDTH = DEF_ELEM_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         mat_valid,
  output logic                         mat_stall,
  input  logic signed [ELEM_WIDTH-1:0] m00,
  input  logic signed [ELEM_WIDTH-1:0] m01,
  input  logic signed [ELEM_WIDTH-1:0] m02,
  input  logic signed [ELEM_WIDTH-1:0] m10,
  input  logic signed [ELEM_WIDTH-1:0] m11,
  input  logic signed [ELEM_WIDTH-1:0] m12,
  input  logic signed [ELEM_WIDTH-1:0] m20,
  input  logic signed [ELEM_WIDTH-1:0] m21,
  input  logic signed [ELEM_WIDTH-1:0] m22,
  output logic                         inv_valid,
  input  logic                         inv_stall,
  output logic signed [ELEM_WIDTH-1:0] r00,
  output logic signed [ELEM_WIDTH-1:0] r01,
  output logic signed [ELEM_WIDTH-1:0] r02,
  output logic signed [ELEM_WIDTH-1:0] r10,
  output logic signed [ELEM_WIDTH-1:0] r11,
  output logic signed [ELEM_WIDTH-1:0] r12,
  output logic signed [ELEM_WIDTH-1:0] r20,
  output logic signed [ELEM_WIDTH-1:0] r21,
  output logic signed [ELEM_WIDTH-1:0] r22,
  output logic                         singular,
  output logic                         saturated
);

  typedef logic [N-1:0][N-1:0][ELEM_WIDTH-1:0] mat_t;

  logic en;
  logic st_v   [N+1];
  mat_t st_mat [N+1];
  ctl_t st_ctl [N+1];

  logic skid_full;

  assign en        = !skid_full;
  assign mat_stall = skid_full;

  assign st_v[0]         = mat_valid;
  assign st_mat[0][0][0] = m00;
  assign st_mat[0][0][1] = m01;
  assign st_mat[0][0][2] = m02;
  assign st_mat[0][1][0] = m10;
  assign st_mat[0][1][1] = m11;
  assign st_mat[0][1][2] = m12;
  assign st_mat[0][2][0] = m20;
  assign st_mat[0][2][1] = m21;
  assign st_mat[0][2][2] = m22;
  assign st_ctl[0]       = '0;

  for (genvar s = 0; s < N; s++) begin : g_step
    m3i_step #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .STEP       (s)
    ) u_step (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld_i (st_v[s]),
      .mat_i (st_mat[s]),
      .ctl_i (st_ctl[s]),
      .vld_o (st_v[s+1]),
      .mat_o (st_mat[s+1]),
      .ctl_o (st_ctl[s+1])
    );
  end

  // undo the row exchanges by swapping columns, last step first
  mat_t                  fin;
  logic [ELEM_WIDTH-1:0] tmp;
  logic                  fin_sing;
  logic                  fin_sat;

  always_comb begin
    fin = st_mat[N];
    tmp = '0;
    for (int n = N - 1; n >= 0; n--) begin
      if (st_ctl[N].prow[n] != st_ctl[N].pcol[n]) begin
        for (int k = 0; k < N; k++) begin
          tmp = fin[k][st_ctl[N].prow[n]];
          fin[k][st_ctl[N].prow[n]] = fin[k][st_ctl[N].pcol[n]];
          fin[k][st_ctl[N].pcol[n]] = tmp;
        end
      end
    end
    fin_sing = st_ctl[N].sing;
    fin_sat  = st_ctl[N].sat & !st_ctl[N].sing;
    if (st_ctl[N].sing) begin
      fin = '0;
    end
  end

  // output register plus one skid entry
  mat_t o_mat, s_mat;
  logic o_sing, o_sat, s_sing, s_sat;
  logic push, pop;

  assign push = en && st_v[N];
  assign pop  = inv_valid && !inv_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (pop) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (!inv_valid || pop) begin
        inv_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (pop) begin
      inv_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        o_mat  <= s_mat;
        o_sing <= s_sing;
        o_sat  <= s_sat;
      end
    end else if (push) begin
      if (!inv_valid || pop) begin
        o_mat  <= fin;
        o_sing <= fin_sing;
        o_sat  <= fin_sat;
      end else begin
        s_mat  <= fin;
        s_sing <= fin_sing;
        s_sat  <= fin_sat;
      end
    end
  end

  assign r00       = o_mat[0][0];
  assign r01       = o_mat[0][1];
  assign r02       = o_mat[0][2];
  assign r10       = o_mat[1][0];
  assign r11       = o_mat[1][1];
  assign r12       = o_mat[1][2];
  assign r20       = o_mat[2][0];
  assign r21       = o_mat[2][1];
  assign r22       = o_mat[2][2];
  assign singular  = o_sing;
  assign saturated = o_sat;

endmodule
